// ===== rtl/qmm_pkg.sv =====
`timescale 1ns / 1ps
package qmm_pkg;

    // Field widths
    localparam int CMD_W    = 24;
    localparam int THRUST_W = 16;
    localparam int TERM_W   = CMD_W + 2;   // sum of three commands
    localparam int MAG_W    = CMD_W + 1;   // |term| <= 3 * 2^23
    localparam int LIMIT_W  = 14;          // bits of the integer limit

    // Defaults for the top-level parameters
    localparam int FRAC_BITS_DEF   = 8;
    localparam int MOTOR_COUNT_DEF = 4;

    // Mixer constants
    localparam int LIMIT_UNITS  = 10000;
    localparam int DUTY_MAX_PCT = 100;

endpackage

// ===== rtl/quad_motor_mixer_desaturate_core.sv =====
`timescale 1ns / 1ps
// Channel   Ports                                           Direction
// --------  ----------------------------------------------  ---------
// s_        s_valid/s_ready, roll/pitch/yaw cmd, thrust,    in
//           disarm
// m_        m_valid/m_ready, four duties, scaled_down       out
//
// One item per cycle while no stall at m_ holds the pipeline. There are seven
// mix and scale stages, MAG_W + 1 divider stages, one radicand stage, DUTY_W
// root stages and the output register. The restoring divider and square root
// yield one quotient bit and one root bit per stage, which sets the depth.
// aresetn (synchronous, active low) clears only the valid bits.
// A stall at m_ holds every stage in place; s_ready follows it directly.
module quad_motor_mixer_desaturate_core #(
    parameter int FRAC_BITS   = qmm_pkg::FRAC_BITS_DEF,
    parameter int MOTOR_COUNT = qmm_pkg::MOTOR_COUNT_DEF,
    parameter int DUTY_W      = FRAC_BITS + 7
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [qmm_pkg::CMD_W-1:0]  s_roll_cmd,
    input  logic signed [qmm_pkg::CMD_W-1:0]  s_pitch_cmd,
    input  logic signed [qmm_pkg::CMD_W-1:0]  s_yaw_cmd,
    input  logic [qmm_pkg::THRUST_W-1:0]      s_thrust,
    input  logic                              s_disarm,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [DUTY_W-1:0]                 m_duty_front_a,
    output logic [DUTY_W-1:0]                 m_duty_front_b,
    output logic [DUTY_W-1:0]                 m_duty_rear_a,
    output logic [DUTY_W-1:0]                 m_duty_rear_b,
    output logic                              m_scaled_down
);
    import qmm_pkg::*;

    localparam int TT_W  = 2 * THRUST_W;
    localparam int HW    = TT_W + 1 - FRAC_BITS;        // width of h
    localparam int LW    = LIMIT_W + FRAC_BITS + 1;     // signed limit
    localparam int AW0   = (TERM_W > HW + 1) ? TERM_W : HW + 1;
    localparam int AW    = ((AW0 > LW) ? AW0 : LW) + 2; // overshoot math
    localparam int PW    = 2 * MAG_W;
    localparam int DIVN  = MAG_W;
    localparam int XW    = 2 * DUTY_W;
    localparam longint DM   = longint'(DUTY_MAX_PCT) << FRAC_BITS;
    localparam longint THR  = ((DM + 1) * (DM + 1) + (longint'(1) << FRAC_BITS) - 1)
                              >> FRAC_BITS;
    localparam logic signed [AW-1:0] LIM_A = AW'(longint'(LIMIT_UNITS) << FRAC_BITS);
    localparam logic signed [AW-1:0] THR_A = AW'(THR);
    localparam logic [DUTY_W-1:0]    DM_D  = DUTY_W'(DM);
    localparam logic [TT_W:0]        HALF  = (TT_W+1)'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        logic [MOTOR_COUNT-1:0] neg;
        logic [HW-1:0]          h;
        logic                   sat;
        logic                   scaled;
        logic                   disarm;
    } side_t;

    logic m_valid_reg;
    logic adv;
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // ---------------- stage 1: mix and square thrust ----------------
    logic                     s1_valid_reg;
    logic signed [TERM_W-1:0] s1_m_reg [MOTOR_COUNT];
    logic [TT_W-1:0]          s1_tt_reg;
    logic                     s1_disarm_reg;
    logic signed [TERM_W-1:0] r_e, p_e, y_e;

    assign r_e = TERM_W'(s_roll_cmd);
    assign p_e = TERM_W'(s_pitch_cmd);
    assign y_e = TERM_W'(s_yaw_cmd);

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_m_reg[0]   <= r_e + p_e + y_e;
            s1_m_reg[1]   <= r_e - p_e - y_e;
            s1_m_reg[2]   <= -r_e - p_e + y_e;
            s1_m_reg[3]   <= -r_e + p_e - y_e;
            s1_tt_reg     <= s_thrust * s_thrust;
            s1_disarm_reg <= s_disarm;
        end
    end

    // ---------------- stage 2: round h ----------------
    logic                     s2_valid_reg;
    logic signed [TERM_W-1:0] s2_m_reg [MOTOR_COUNT];
    logic [HW-1:0]            s2_h_reg;
    logic                     s2_disarm_reg;
    logic [TT_W:0]            tt_rnd;

    assign tt_rnd = {1'b0, s1_tt_reg} + HALF;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_m_reg      <= s1_m_reg;
            s2_h_reg      <= tt_rnd[TT_W:FRAC_BITS];
            s2_disarm_reg <= s1_disarm_reg;
        end
    end

    // ---------------- stage 3: overshoot and candidate ratios ----------------
    logic               s3_valid_reg;
    logic [MAG_W-1:0]   s3_a_reg   [MOTOR_COUNT];
    logic [MAG_W-1:0]   s3_num_reg [MOTOR_COUNT];
    logic [MAG_W-1:0]   s3_den_reg [MOTOR_COUNT];
    side_t              s3_sd_reg;

    logic signed [AW-1:0]   ov_d   [MOTOR_COUNT];
    logic signed [AW-1:0]   ov_den [MOTOR_COUNT];
    logic [MAG_W-1:0]       ov_a   [MOTOR_COUNT];
    logic [MOTOR_COUNT-1:0] ov_cand, ov_sat, ov_neg;

    always_comb begin
        logic signed [AW-1:0] me, he, d1, d2;
        for (int i = 0; i < MOTOR_COUNT; i++) begin
            me = AW'(s2_m_reg[i]);
            he = AW'({1'b0, s2_h_reg});
            d1 = me + he - LIM_A;
            d2 = -me - he;
            ov_d[i] = (d1 > d2) ? d1 : d2;
            if (ov_d[i] < 0) ov_d[i] = '0;
            ov_neg[i] = s2_m_reg[i][TERM_W-1];
            ov_a[i]   = ov_neg[i] ? MAG_W'(-s2_m_reg[i]) : MAG_W'(s2_m_reg[i]);
            ov_den[i] = AW'({1'b0, ov_a[i]}) - ov_d[i];
            ov_cand[i] = (s2_m_reg[i] != '0) && (ov_den[i] > 0);
            ov_sat[i]  = (s2_m_reg[i] != '0) && (ov_den[i] <= 0);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < MOTOR_COUNT; i++) begin
                s3_a_reg[i]   <= ov_a[i];
                s3_num_reg[i] <= ov_cand[i] ? ov_a[i] : MAG_W'(1);
                s3_den_reg[i] <= ov_cand[i] ? ov_den[i][MAG_W-1:0] : MAG_W'(1);
            end
            s3_sd_reg.neg    <= ov_neg;
            s3_sd_reg.h      <= s2_h_reg;
            s3_sd_reg.sat    <= |ov_sat;
            s3_sd_reg.scaled <= 1'b0;
            s3_sd_reg.disarm <= s2_disarm_reg;
        end
    end

    // ---------------- stage 4: cross products within pairs ----------------
    logic             s4_valid_reg;
    logic [MAG_W-1:0] s4_a_reg   [MOTOR_COUNT];
    logic [MAG_W-1:0] s4_num_reg [MOTOR_COUNT];
    logic [MAG_W-1:0] s4_den_reg [MOTOR_COUNT];
    logic [PW-1:0]    s4_pc_reg  [2];
    logic [PW-1:0]    s4_pi_reg  [2];
    side_t            s4_sd_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_a_reg   <= s3_a_reg;
            s4_num_reg <= s3_num_reg;
            s4_den_reg <= s3_den_reg;
            s4_sd_reg  <= s3_sd_reg;
            for (int j = 0; j < 2; j++) begin
                // challenger (later motor) against incumbent
                s4_pc_reg[j] <= s3_num_reg[2*j+1] * s3_den_reg[2*j];
                s4_pi_reg[j] <= s3_num_reg[2*j] * s3_den_reg[2*j+1];
            end
        end
    end

    // ---------------- stage 5: pick the larger ratio of each pair ----------------
    logic             s5_valid_reg;
    logic [MAG_W-1:0] s5_a_reg   [MOTOR_COUNT];
    logic [MAG_W-1:0] s5_num_reg [2];
    logic [MAG_W-1:0] s5_den_reg [2];
    side_t            s5_sd_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s5_a_reg  <= s4_a_reg;
            s5_sd_reg <= s4_sd_reg;
            for (int j = 0; j < 2; j++) begin
                if (s4_pc_reg[j] > s4_pi_reg[j]) begin
                    s5_num_reg[j] <= s4_num_reg[2*j+1];
                    s5_den_reg[j] <= s4_den_reg[2*j+1];
                end else begin
                    s5_num_reg[j] <= s4_num_reg[2*j];
                    s5_den_reg[j] <= s4_den_reg[2*j];
                end
            end
        end
    end

    // ---------------- stage 6: cross products between pairs ----------------
    logic             s6_valid_reg;
    logic [MAG_W-1:0] s6_a_reg   [MOTOR_COUNT];
    logic [MAG_W-1:0] s6_num_reg [2];
    logic [MAG_W-1:0] s6_den_reg [2];
    logic [PW-1:0]    s6_pc_reg, s6_pi_reg;
    side_t            s6_sd_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s6_a_reg   <= s5_a_reg;
            s6_num_reg <= s5_num_reg;
            s6_den_reg <= s5_den_reg;
            s6_sd_reg  <= s5_sd_reg;
            s6_pc_reg  <= s5_num_reg[1] * s5_den_reg[0];
            s6_pi_reg  <= s5_num_reg[0] * s5_den_reg[1];
        end
    end

    // ---------------- stage 7: final scale factor ----------------
    logic             s7_valid_reg;
    logic [MAG_W-1:0] s7_a_reg [MOTOR_COUNT];
    logic [MAG_W-1:0] s7_fnum_reg, s7_fden_reg;
    side_t            s7_sd_reg;
    logic             pick_hi;

    assign pick_hi = s6_pc_reg > s6_pi_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s7_a_reg    <= s6_a_reg;
            s7_fnum_reg <= pick_hi ? s6_num_reg[1] : s6_num_reg[0];
            s7_fden_reg <= pick_hi ? s6_den_reg[1] : s6_den_reg[0];
            s7_sd_reg   <= s6_sd_reg;
        end
    end

    // ---------------- divider lanes: q = |m| * fden / fnum ----------------
    // Index 0 holds the dividend product; each stage yields one quotient bit.
    logic             dv_valid_reg [DIVN+1];
    logic [MAG_W-1:0] dv_rem_reg   [DIVN+1][MOTOR_COUNT];
    logic [MAG_W-1:0] dv_low_reg   [DIVN+1][MOTOR_COUNT];
    logic [MAG_W-1:0] dv_q_reg     [DIVN+1][MOTOR_COUNT];
    logic [MAG_W-1:0] dv_fnum_reg  [DIVN+1];
    side_t            dv_sd_reg    [DIVN+1];
    logic [PW-1:0]    dv_prod      [MOTOR_COUNT];
    side_t            dv_sd_in;

    always_comb begin
        for (int i = 0; i < MOTOR_COUNT; i++) begin
            dv_prod[i] = s7_a_reg[i] * s7_fden_reg;
        end
    end

    // scaled flag joins the side data here
    always_comb begin
        dv_sd_in        = s7_sd_reg;
        dv_sd_in.scaled = s7_sd_reg.sat || (s7_fnum_reg > s7_fden_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < MOTOR_COUNT; i++) begin
                dv_rem_reg[0][i] <= dv_prod[i][PW-1:MAG_W];
                dv_low_reg[0][i] <= dv_prod[i][MAG_W-1:0];
                dv_q_reg[0][i]   <= '0;
            end
            dv_fnum_reg[0] <= s7_fnum_reg;
            dv_sd_reg[0]   <= dv_sd_in;
        end
    end

    for (genvar k = 0; k < DIVN; k++) begin : g_div
        logic [MAG_W:0] trial [MOTOR_COUNT];
        logic [MAG_W:0] diff  [MOTOR_COUNT];

        always_comb begin
            for (int i = 0; i < MOTOR_COUNT; i++) begin
                trial[i] = {dv_rem_reg[k][i], dv_low_reg[k][i][MAG_W-1]};
                diff[i]  = trial[i] - {1'b0, dv_fnum_reg[k]};
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                for (int i = 0; i < MOTOR_COUNT; i++) begin
                    if (!diff[i][MAG_W]) begin
                        dv_rem_reg[k+1][i] <= diff[i][MAG_W-1:0];
                        dv_q_reg[k+1][i]   <= {dv_q_reg[k][i][MAG_W-2:0], 1'b1};
                    end else begin
                        dv_rem_reg[k+1][i] <= trial[i][MAG_W-1:0];
                        dv_q_reg[k+1][i]   <= {dv_q_reg[k][i][MAG_W-2:0], 1'b0};
                    end
                    dv_low_reg[k+1][i] <= {dv_low_reg[k][i][MAG_W-2:0], 1'b0};
                end
                dv_fnum_reg[k+1] <= dv_fnum_reg[k];
                dv_sd_reg[k+1]   <= dv_sd_reg[k];
            end
        end
    end

    // ---------------- radicand and clamp ----------------
    logic                 rs_valid_reg;
    logic [XW-1:0]        rs_x_reg   [MOTOR_COUNT];
    logic [MOTOR_COUNT-1:0] rs_big_reg;
    logic                 rs_scaled_reg, rs_disarm_reg;
    logic signed [AW-1:0] rad [MOTOR_COUNT];
    side_t                dv_last;

    assign dv_last = dv_sd_reg[DIVN];

    always_comb begin
        logic signed [AW-1:0] sq;
        for (int i = 0; i < MOTOR_COUNT; i++) begin
            sq = AW'({1'b0, dv_q_reg[DIVN][i]});
            if (dv_last.sat)          sq = '0;
            else if (dv_last.neg[i])  sq = -sq;
            rad[i] = sq + AW'({1'b0, dv_last.h});
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < MOTOR_COUNT; i++) begin
                if (rad[i] < 0) begin
                    rs_x_reg[i]   <= '0;
                    rs_big_reg[i] <= 1'b0;
                end else if (rad[i] >= THR_A) begin
                    rs_x_reg[i]   <= '0;
                    rs_big_reg[i] <= 1'b1;
                end else begin
                    rs_x_reg[i]   <= XW'(rad[i]) << FRAC_BITS;
                    rs_big_reg[i] <= 1'b0;
                end
            end
            rs_scaled_reg <= dv_last.scaled;
            rs_disarm_reg <= dv_last.disarm;
        end
    end

    // ---------------- square root lanes: one root bit per stage ----------------
    logic                   sq_valid_reg  [DUTY_W+1];
    logic [DUTY_W+1:0]      sq_rem_reg    [DUTY_W+1][MOTOR_COUNT];
    logic [DUTY_W-1:0]      sq_root_reg   [DUTY_W+1][MOTOR_COUNT];
    logic [XW-1:0]          sq_x_reg      [DUTY_W+1][MOTOR_COUNT];
    logic [MOTOR_COUNT-1:0] sq_big_reg    [DUTY_W+1];
    logic                   sq_scaled_reg [DUTY_W+1];
    logic                   sq_disarm_reg [DUTY_W+1];

    always_comb begin
        for (int i = 0; i < MOTOR_COUNT; i++) begin
            sq_rem_reg[0][i]  = '0;
            sq_root_reg[0][i] = '0;
            sq_x_reg[0][i]    = rs_x_reg[i];
        end
        sq_big_reg[0]    = rs_big_reg;
        sq_scaled_reg[0] = rs_scaled_reg;
        sq_disarm_reg[0] = rs_disarm_reg;
        sq_valid_reg[0]  = rs_valid_reg;
    end

    for (genvar k = 0; k < DUTY_W; k++) begin : g_sqrt
        logic [DUTY_W+1:0] t_rem [MOTOR_COUNT];
        logic [DUTY_W+1:0] t_try [MOTOR_COUNT];

        always_comb begin
            for (int i = 0; i < MOTOR_COUNT; i++) begin
                t_rem[i] = {sq_rem_reg[k][i][DUTY_W-1:0], sq_x_reg[k][i][XW-1:XW-2]};
                t_try[i] = {sq_root_reg[k][i], 2'b01};
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                for (int i = 0; i < MOTOR_COUNT; i++) begin
                    if (t_rem[i] >= t_try[i]) begin
                        sq_rem_reg[k+1][i]  <= t_rem[i] - t_try[i];
                        sq_root_reg[k+1][i] <= {sq_root_reg[k][i][DUTY_W-2:0], 1'b1};
                    end else begin
                        sq_rem_reg[k+1][i]  <= t_rem[i];
                        sq_root_reg[k+1][i] <= {sq_root_reg[k][i][DUTY_W-2:0], 1'b0};
                    end
                    sq_x_reg[k+1][i] <= {sq_x_reg[k][i][XW-3:0], 2'b00};
                end
                sq_big_reg[k+1]    <= sq_big_reg[k];
                sq_scaled_reg[k+1] <= sq_scaled_reg[k];
                sq_disarm_reg[k+1] <= sq_disarm_reg[k];
            end
        end
    end

    // ---------------- output register ----------------
    logic [DUTY_W-1:0] m_duty_reg [MOTOR_COUNT];
    logic              m_scaled_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < MOTOR_COUNT; i++) begin
                if (sq_disarm_reg[DUTY_W])      m_duty_reg[i] <= '0;
                else if (sq_big_reg[DUTY_W][i]) m_duty_reg[i] <= DM_D;
                else                            m_duty_reg[i] <= sq_root_reg[DUTY_W][i];
            end
            m_scaled_reg <= sq_scaled_reg[DUTY_W];
        end
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            for (int k = 0; k <= DIVN; k++) dv_valid_reg[k] <= 1'b0;
            rs_valid_reg <= 1'b0;
            for (int k = 1; k <= DUTY_W; k++) sq_valid_reg[k] <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            s1_valid_reg    <= s_valid;
            s2_valid_reg    <= s1_valid_reg;
            s3_valid_reg    <= s2_valid_reg;
            s4_valid_reg    <= s3_valid_reg;
            s5_valid_reg    <= s4_valid_reg;
            s6_valid_reg    <= s5_valid_reg;
            s7_valid_reg    <= s6_valid_reg;
            dv_valid_reg[0] <= s7_valid_reg;
            for (int k = 0; k < DIVN; k++) dv_valid_reg[k+1] <= dv_valid_reg[k];
            rs_valid_reg    <= dv_valid_reg[DIVN];
            for (int k = 0; k < DUTY_W; k++) sq_valid_reg[k+1] <= sq_valid_reg[k];
            m_valid_reg     <= sq_valid_reg[DUTY_W];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_duty_front_a = m_duty_reg[0];
    assign m_duty_front_b = m_duty_reg[1];
    assign m_duty_rear_a  = m_duty_reg[2];
    assign m_duty_rear_b  = m_duty_reg[3];
    assign m_scaled_down  = m_scaled_reg;

endmodule

// ===== bench/quad_motor_mixer_desaturate_checker.sv =====
`timescale 1ns / 1ps
module quad_motor_mixer_desaturate_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic signed [qmm_pkg::CMD_W-1:0]   s_roll_cmd,
    input  logic signed [qmm_pkg::CMD_W-1:0]   s_pitch_cmd,
    input  logic signed [qmm_pkg::CMD_W-1:0]   s_yaw_cmd,
    input  logic [qmm_pkg::THRUST_W-1:0]       s_thrust,
    input  logic                               s_disarm,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic [14:0]                        m_duty_front_a,
    input  logic [14:0]                        m_duty_front_b,
    input  logic [14:0]                        m_duty_rear_a,
    input  logic [14:0]                        m_duty_rear_b,
    input  logic                               m_scaled_down,
    output int                                 err_count,
    output int                                 pending
);
    localparam int FB = 8;

    typedef struct packed {
        logic [3:0][14:0] duty;
        logic             scaled;
    } mix_out_t;

    mix_out_t duty_q[$];

    assign pending = duty_q.size();

    function automatic longint root64(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    // Mix, find the common scale factor, then take the root of each motor
    function automatic mix_out_t mix_motors(longint r, longint p, longint y,
                                            longint unsigned t, logic dis);
        mix_out_t o;
        longint m [4];
        longint h, lim, dmax, fnum, fden, a, d, dn, q, s, rad, du;
        bit sat;
        h = longint'((t * t + (64'd1 << (FB - 1))) >> FB);
        lim = longint'(qmm_pkg::LIMIT_UNITS) << FB;
        dmax = longint'(qmm_pkg::DUTY_MAX_PCT) << FB;
        fnum = 1;
        fden = 1;
        sat = 0;
        m[0] = r + p + y;
        m[1] = r - p - y;
        m[2] = -r - p + y;
        m[3] = -r + p - y;
        for (int i = 0; i < 4; i++) begin
            a = m[i] < 0 ? -m[i] : m[i];
            d = m[i] + h - lim;
            if (-m[i] - h > d) d = -m[i] - h;
            if (d < 0) d = 0;
            if (m[i] != 0) begin
                dn = a - d;
                if (dn <= 0) sat = 1;
                else if (a * fden > fnum * dn) begin
                    fnum = a;
                    fden = dn;
                end
            end
        end
        for (int i = 0; i < 4; i++) begin
            s = 0;
            if (!sat) begin
                q = ((m[i] < 0 ? -m[i] : m[i]) * fden) / fnum;
                s = m[i] < 0 ? -q : q;
            end
            rad = s + h;
            if (rad < 0) rad = 0;
            du = root64(longint'(rad) << FB);
            if (du > dmax) du = dmax;
            if (dis) du = 0;
            o.duty[i] = du[14:0];
        end
        o.scaled = sat || (fnum > fden);
        return o;
    endfunction

    // Predict on input accept, compare on output accept
    always @(posedge aclk) begin
        mix_out_t e;
        mix_out_t got;
        if (aresetn) begin
            if (s_valid && s_ready)
                duty_q.push_back(mix_motors(longint'(s_roll_cmd), longint'(s_pitch_cmd),
                    longint'(s_yaw_cmd), longint'(s_thrust), s_disarm));
            if (m_valid && m_ready) begin
                got.duty[0] = m_duty_front_a;
                got.duty[1] = m_duty_front_b;
                got.duty[2] = m_duty_rear_a;
                got.duty[3] = m_duty_rear_b;
                got.scaled  = m_scaled_down;
                if (duty_q.size() == 0) begin
                    err_count <= err_count + 1;
                    if (err_count < 10) $display("unexpected item %h", got);
                end else begin
                    e = duty_q.pop_front();
                    if (e != got) begin
                        err_count <= err_count + 1;
                        if (err_count < 10)
                            $display("mismatch: duties exp %0d %0d %0d %0d sd %0b",
                                e.duty[0], e.duty[1], e.duty[2], e.duty[3], e.scaled,
                                ", got %0d %0d %0d %0d sd %0b",
                                got.duty[0], got.duty[1], got.duty[2], got.duty[3],
                                got.scaled);
                    end
                end
            end
        end
    end

    initial err_count = 0;
endmodule

// ===== bench/quad_motor_mixer_desaturate_core_tb.sv =====
`timescale 1ns / 1ps
module quad_motor_mixer_desaturate_core_tb;
    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic signed [23:0] s_roll_cmd = 0, s_pitch_cmd = 0, s_yaw_cmd = 0;
    logic [15:0] s_thrust = 0;
    logic s_disarm = 0;
    logic m_valid;
    logic m_ready = 0;
    logic [14:0] m_duty_front_a, m_duty_front_b, m_duty_rear_a, m_duty_rear_b;
    logic m_scaled_down;
    int err_count, pending;
    bit hold_rx = 0;

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    quad_motor_mixer_desaturate_core dut (.*);

    quad_motor_mixer_desaturate_checker chk (.*);

    // Random command value, biased toward small magnitudes and extremes
    function automatic logic [23:0] rand_cmd();
        case ($urandom_range(0, 5))
            0: return 24'($urandom);
            1: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            2: return 24'($signed($urandom_range(0, 8000)) - 4000);
            3: return 24'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return 24'($signed($urandom_range(0, 400000)) - 200000);
        endcase
    endfunction

    // Valid drops only when the sender actually idles
    task automatic send_item(logic [23:0] r, logic [23:0] p, logic [23:0] y,
                             logic [15:0] t, logic d, bit idle);
        int gap;
        gap = idle ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_roll_cmd <= r;
        s_pitch_cmd <= p;
        s_yaw_cmd <= y;
        s_thrust <= t;
        s_disarm <= d;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Receiver: random stalls, or a long hold-off when requested
    initial begin
        int w;
        forever begin
            @(posedge aclk);
            if (hold_rx) begin
                m_ready <= 0;
                repeat (120) @(posedge aclk);
                hold_rx = 0;
            end
            w = $urandom_range(0, 3) == 0 ? $urandom_range(0, 18) : 0;
            if (w > 0) begin
                m_ready <= 0;
                repeat (w) @(posedge aclk);
            end
            m_ready <= 1;
        end
    end

    initial begin
        int cnt;
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // Directed: extremes, zero terms, saturation, clamps, disarm
        send_item(24'd0, 24'd0, 24'd0, 16'd0, 1'b0, 1'b0);
        send_item(24'd0, 24'd0, 24'd0, 16'hFFFF, 1'b0, 1'b0);
        send_item(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 1'b0, 1'b0);
        send_item(24'h800000, 24'h800000, 24'h800000, 16'd0, 1'b0, 1'b0);
        send_item(24'h7FFFFF, 24'h800000, 24'd0, 16'h1000, 1'b0, 1'b0);
        send_item(24'd256, 24'd0, 24'd0, 16'd0, 1'b0, 1'b0);
        send_item(24'hFFFF00, 24'd0, 24'd0, 16'd0, 1'b0, 1'b0);
        send_item(24'd1000, 24'd0, 24'd0, 16'd25600, 1'b0, 1'b0);
        send_item(24'd500000, 24'd0, 24'd0, 16'd25600, 1'b0, 1'b0);
        send_item(24'd0, 24'd2560000, 24'd0, 16'd12800, 1'b0, 1'b0);
        send_item(24'd0, 24'd0, 24'hF00000, 16'd12800, 1'b0, 1'b0);
        send_item(24'd100, 24'd200, 24'd300, 16'd9000, 1'b0, 1'b0);
        send_item(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 1'b1, 1'b0);
        send_item(24'h555555, 24'hAAAAAA, 24'h555555, 16'hAAAA, 1'b1, 1'b0);
        send_item(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 16'h5555, 1'b0, 1'b0);
        send_item(24'd3000, 24'd3000, 24'd0, 16'd16000, 1'b0, 1'b0);
        // Long receiver hold-off while the sender keeps offering
        hold_rx = 1;
        for (int i = 0; i < 80; i++)
            send_item(rand_cmd(), rand_cmd(), rand_cmd(), 16'($urandom),
                      $urandom_range(0, 9) == 0, 1'b0);
        // Sender pauses until every expected item has come back
        s_valid <= 0;
        cnt = 0;
        while (pending != 0 && cnt < 100000) begin
            @(posedge aclk);
            cnt++;
        end
        for (int i = 0; i < 360; i++)
            send_item(rand_cmd(), rand_cmd(), rand_cmd(), 16'($urandom),
                      $urandom_range(0, 9) == 0, (i / 60) % 2 == 0);
        s_valid <= 0;
        cnt = 0;
        while (pending != 0 && cnt < 200000) begin
            @(posedge aclk);
            cnt++;
        end
        repeat (60) @(posedge aclk);
        if (err_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end
endmodule

// ===== quad_motor_mixer_desaturate_core.f =====
rtl/qmm_pkg.sv
rtl/quad_motor_mixer_desaturate_core.sv
bench/quad_motor_mixer_desaturate_checker.sv
bench/quad_motor_mixer_desaturate_core_tb.sv
